@@ hw/rtl/psvf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvf_pkg
// types, widths and helpers shared by the straight vertex filter modules
// ----------------------------------------------------------------------------
package psvf_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_WIDTH  = 36;
    localparam int COS_WIDTH  = 16;
    localparam int COS_SHIFT  = 30;                  // 2 x fraction bits of the cosine
    localparam int BW         = 2 * COORD_BITS + 2;  // widest serial multiplier
    localparam int AW         = 4 * COORD_BITS + 37; // accumulator width
    localparam int DD_W       = 4 * COORD_BITS + 4;  // squared dot product

    localparam logic [CFG_WIDTH-1:0] MIN_SPAN_RESET = '0;
    localparam logic [CFG_WIDTH-1:0] MAX_GAP_RESET  = '1;
    localparam logic [COS_WIDTH-1:0] COS_RESET      = COS_WIDTH'(32768);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   end_of_path;
    } s_word_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
        coord_t qz;
        logic   final_point;
    } m_word_t;

    typedef enum logic [1:0] {
        CFG_MIN_SPAN = 2'd0,
        CFG_MAX_GAP  = 2'd1,
        CFG_COS      = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEEN_NONE  = 2'd0,
        SEEN_FIRST = 2'd1,
        SEEN_PEND  = 2'd2
    } seen_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_EMIT_PEND,
        ST_EMIT_CUR
    } state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ISSUE,
        SQ_WAIT
    } sq_state_t;

    typedef enum logic [4:0] {
        OP_SPAN0, OP_SPAN1, OP_SPAN2,
        OP_GAP0,  OP_GAP1,  OP_GAP2,
        OP_CX0,   OP_CX1,
        OP_CY0,   OP_CY1,
        OP_CZ0,   OP_CZ1,
        OP_DOT0,  OP_DOT1,  OP_DOT2,
        OP_N1_0,  OP_N1_1,  OP_N1_2,
        OP_N2_0,  OP_N2_1,  OP_N2_2,
        OP_DD,    OP_NN,    OP_NC,    OP_NCC
    } op_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_cmd_t;

    typedef struct packed {
        logic valid;
        logic keep;
    } verdict_t;

    // sign and magnitude of a coordinate difference
    typedef struct packed {
        logic                  neg;
        logic [COORD_BITS-1:0] mag;
    } smag_t;

    typedef smag_t [2:0] smag3_t;

    function automatic smag_t sdiff(coord_t a, coord_t b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] t;
        smag_t               r;
        d     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        t     = d[COORD_BITS] ? (~d + 1'b1) : d;
        r.neg = d[COORD_BITS];
        r.mag = t[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic smag3_t pdiff(point_t a, point_t b);
        smag3_t r;
        r[0] = sdiff(a.x, b.x);
        r[1] = sdiff(a.y, b.y);
        r[2] = sdiff(a.z, b.z);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/psvf_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvf_mac
// bit-serial shift-add multiply-accumulate, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module psvf_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  psvf_pkg::mac_cmd_t               cmd,
    input  logic [psvf_pkg::AW-1:0]          a_in,
    input  logic [psvf_pkg::BW-1:0]          b_in,
    output logic                             done,
    output logic signed [psvf_pkg::AW-1:0]   acc
);
    import psvf_pkg::*;

    logic                 run_reg, run_next;
    logic                 sub_reg, sub_next;
    logic [AW-1:0]        a_sh_reg, a_sh_next;
    logic [BW-1:0]        b_sh_reg, b_sh_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    assign done = run_reg && (b_sh_reg == '0);
    assign acc  = acc_reg;

    always_comb begin
        run_next  = run_reg;
        sub_next  = sub_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        if (cmd.start) begin
            run_next  = 1'b1;
            sub_next  = cmd.sub;
            a_sh_next = a_in;
            b_sh_next = b_in;
            acc_next  = cmd.clear ? '0 : acc_reg;
        end else if (done) begin
            run_next = 1'b0;
        end else if (run_reg) begin
            if (b_sh_reg[0]) begin
                acc_next = sub_reg ? acc_reg - signed'(a_sh_reg)
                                   : acc_reg + signed'(a_sh_reg);
            end
            a_sh_next = a_sh_reg << 1;
            b_sh_next = b_sh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        sub_reg  <= sub_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
    end

    a_start_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (!run_reg || done))
        else $error("mac started while busy");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !cmd.start) |=> !run_reg)
        else $error("mac kept running after done");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!run_reg && !cmd.start) |=> $stable(acc_reg))
        else $error("accumulator moved while idle");

endmodule
`default_nettype wire

@@ hw/rtl/psvf_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvf_seq
// sequencer that judges the pending vertex with the shared serial mac
// ----------------------------------------------------------------------------
module psvf_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 go,
    input  psvf_pkg::point_t                     pt_prev,
    input  psvf_pkg::point_t                     pt_pend,
    input  psvf_pkg::point_t                     pt_cur,
    input  psvf_pkg::point_t                     pt_kept,
    input  logic [psvf_pkg::CFG_WIDTH-1:0]       min_span_sq,
    input  logic [psvf_pkg::CFG_WIDTH-1:0]       max_gap_sq,
    input  logic [psvf_pkg::COS_WIDTH-1:0]       cos_threshold,
    output psvf_pkg::verdict_t                   verdict
);
    import psvf_pkg::*;

    sq_state_t            state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 cx_nz_reg, cx_nz_next;
    logic                 cy_nz_reg, cy_nz_next;
    logic [BW-1:0]        d_reg, d_next;
    logic [BW-1:0]        n1_reg, n1_next;
    logic [BW-1:0]        n2_reg, n2_next;
    logic [DD_W-1:0]      dd_reg, dd_next;

    mac_cmd_t             cmd;
    logic [AW-1:0]        a_op;
    logic [BW-1:0]        b_op;
    logic                 mac_done;
    logic signed [AW-1:0] acc;

    smag3_t               ds, dg, e1, e2;
    logic signed [AW-1:0] min_w, max_w, lhs_w;
    logic                 fin;
    logic                 keep;

    assign ds = pdiff(pt_cur, pt_prev);
    assign dg = pdiff(pt_pend, pt_kept);
    assign e1 = pdiff(pt_pend, pt_prev);
    assign e2 = pdiff(pt_cur, pt_pend);

    assign min_w = signed'(AW'(min_span_sq));
    assign max_w = signed'(AW'(max_gap_sq));
    assign lhs_w = signed'(AW'({dd_reg, {COS_SHIFT{1'b0}}}));

    psvf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .a_in    (a_op),
        .b_in    (b_op),
        .done    (mac_done),
        .acc     (acc)
    );

    // operand selection for the issued product
    always_comb begin
        a_op      = '0;
        b_op      = '0;
        cmd.start = (state_reg == SQ_ISSUE);
        cmd.clear = 1'b0;
        cmd.sub   = 1'b0;
        unique case (op_reg)
            OP_SPAN0: begin a_op = AW'(ds[0].mag); b_op = BW'(ds[0].mag); cmd.clear = 1'b1; end
            OP_SPAN1: begin a_op = AW'(ds[1].mag); b_op = BW'(ds[1].mag); end
            OP_SPAN2: begin a_op = AW'(ds[2].mag); b_op = BW'(ds[2].mag); end
            OP_GAP0:  begin a_op = AW'(dg[0].mag); b_op = BW'(dg[0].mag); cmd.clear = 1'b1; end
            OP_GAP1:  begin a_op = AW'(dg[1].mag); b_op = BW'(dg[1].mag); end
            OP_GAP2:  begin a_op = AW'(dg[2].mag); b_op = BW'(dg[2].mag); end
            OP_CX0: begin
                a_op = AW'(e1[1].mag); b_op = BW'(e2[2].mag);
                cmd.sub = e1[1].neg ^ e2[2].neg; cmd.clear = 1'b1;
            end
            OP_CX1: begin
                a_op = AW'(e1[2].mag); b_op = BW'(e2[1].mag);
                cmd.sub = ~(e1[2].neg ^ e2[1].neg);
            end
            OP_CY0: begin
                a_op = AW'(e1[2].mag); b_op = BW'(e2[0].mag);
                cmd.sub = e1[2].neg ^ e2[0].neg; cmd.clear = 1'b1;
            end
            OP_CY1: begin
                a_op = AW'(e1[0].mag); b_op = BW'(e2[2].mag);
                cmd.sub = ~(e1[0].neg ^ e2[2].neg);
            end
            OP_CZ0: begin
                a_op = AW'(e1[0].mag); b_op = BW'(e2[1].mag);
                cmd.sub = e1[0].neg ^ e2[1].neg; cmd.clear = 1'b1;
            end
            OP_CZ1: begin
                a_op = AW'(e1[1].mag); b_op = BW'(e2[0].mag);
                cmd.sub = ~(e1[1].neg ^ e2[0].neg);
            end
            OP_DOT0: begin
                a_op = AW'(e1[0].mag); b_op = BW'(e2[0].mag);
                cmd.sub = e1[0].neg ^ e2[0].neg; cmd.clear = 1'b1;
            end
            OP_DOT1: begin
                a_op = AW'(e1[1].mag); b_op = BW'(e2[1].mag);
                cmd.sub = e1[1].neg ^ e2[1].neg;
            end
            OP_DOT2: begin
                a_op = AW'(e1[2].mag); b_op = BW'(e2[2].mag);
                cmd.sub = e1[2].neg ^ e2[2].neg;
            end
            OP_N1_0: begin a_op = AW'(e1[0].mag); b_op = BW'(e1[0].mag); cmd.clear = 1'b1; end
            OP_N1_1: begin a_op = AW'(e1[1].mag); b_op = BW'(e1[1].mag); end
            OP_N1_2: begin a_op = AW'(e1[2].mag); b_op = BW'(e1[2].mag); end
            OP_N2_0: begin a_op = AW'(e2[0].mag); b_op = BW'(e2[0].mag); cmd.clear = 1'b1; end
            OP_N2_1: begin a_op = AW'(e2[1].mag); b_op = BW'(e2[1].mag); end
            OP_N2_2: begin a_op = AW'(e2[2].mag); b_op = BW'(e2[2].mag); end
            OP_DD:   begin a_op = AW'(d_reg);  b_op = d_reg;  cmd.clear = 1'b1; end
            OP_NN:   begin a_op = AW'(n1_reg); b_op = n2_reg; cmd.clear = 1'b1; end
            OP_NC,
            OP_NCC:  begin a_op = unsigned'(acc); b_op = BW'(cos_threshold); cmd.clear = 1'b1; end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    // early exits and the final angle compare
    always_comb begin
        fin  = 1'b0;
        keep = 1'b0;
        if (state_reg == SQ_WAIT && mac_done) begin
            unique case (op_reg)
                OP_SPAN2: if (acc < min_w) begin fin = 1'b1; keep = 1'b0; end
                OP_GAP2:  if (acc >= max_w) begin fin = 1'b1; keep = 1'b1; end
                OP_CZ1:   if (!cx_nz_reg && !cy_nz_reg && acc == '0) begin
                    fin = 1'b1; keep = 1'b0;
                end
                // dot product zero or negative
                OP_DOT2:  if (acc[AW-1] || acc == '0) begin fin = 1'b1; keep = 1'b1; end
                OP_NCC:   begin fin = 1'b1; keep = (lhs_w <= acc); end
                default:  begin fin = 1'b0; keep = 1'b0; end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:  if (go) state_next = SQ_ISSUE;
            SQ_ISSUE: state_next = SQ_WAIT;
            SQ_WAIT:  if (mac_done) state_next = fin ? SQ_IDLE : SQ_ISSUE;
            default:  state_next = SQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        verdict.valid = fin;
        verdict.keep  = keep;
    end

    // partial results
    always_comb begin
        op_next    = op_reg;
        cx_nz_next = cx_nz_reg;
        cy_nz_next = cy_nz_reg;
        d_next     = d_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        dd_next    = dd_reg;
        if (state_reg == SQ_IDLE && go) begin
            op_next = OP_SPAN0;
        end else if (state_reg == SQ_WAIT && mac_done && !fin) begin
            op_next = op_t'(op_reg + 5'd1);
            unique case (op_reg)
                OP_CX1:  cx_nz_next = (acc != '0);
                OP_CY1:  cy_nz_next = (acc != '0);
                OP_DOT2: d_next     = acc[BW-1:0];
                OP_N1_2: n1_next    = acc[BW-1:0];
                OP_N2_2: n2_next    = acc[BW-1:0];
                OP_DD:   dd_next    = acc[DD_W-1:0];
                default: op_next    = op_t'(op_reg + 5'd1);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            op_reg    <= OP_SPAN0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
        cx_nz_reg <= cx_nz_next;
        cy_nz_reg <= cy_nz_next;
        d_reg     <= d_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        dd_reg    <= dd_next;
    end

    a_go_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        go |-> state_reg == SQ_IDLE)
        else $error("judgment started while busy");

    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |=> state_reg == SQ_IDLE)
        else $error("sequencer did not stop after verdict");

    a_issue_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_ISSUE) |=> (state_reg == SQ_WAIT && !mac_done) || mac_done)
        else $error("issue not followed by wait");

endmodule
`default_nettype wire

@@ hw/rtl/polyline_straight_vertex_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_straight_vertex_filter
// streaming 3d polyline simplifier that drops nearly straight vertices
// ----------------------------------------------------------------------------
// Takes one point word at a time and returns the kept points of the polyline.
// The first and last point of every polyline are always kept; an interior
// point is judged once its successor arrives, so its word comes out one input
// later. A judgment runs up to 25 products through one bit-serial shift-add
// multiply-accumulate unit, each product stepping through the bits of its
// multiplier operand: 21 coordinate products, two cosine products and the
// d*d and n1*n2 products. A judgment stops early when the span, gap,
// collinearity or obtuse-turn test already decides. The first point and the
// last point of a two-point line are emitted without a judgment. s_ready is
// high only between words; a finished word waits in the output register, so
// a new point is taken while m_valid is still pending.
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module polyline_straight_vertex_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    // point words in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  psvf_pkg::s_word_t                s_data,
    // kept point words out
    output logic                             m_valid,
    input  logic                             m_ready,
    output psvf_pkg::m_word_t                m_data,
    // register writes
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_addr,
    input  logic [psvf_pkg::CFG_WIDTH-1:0]   cfg_wdata
);
    import psvf_pkg::*;

    // control
    state_t                 state_reg, state_next;
    seen_t                  seen_reg, seen_next;
    logic                   m_valid_reg, m_valid_next;
    // points
    point_t                 prev_reg, prev_next;
    point_t                 pend_reg, pend_next;
    point_t                 kept_reg, kept_next;
    point_t                 cur_reg, cur_next;
    logic                   last_reg, last_next;
    m_word_t                m_data_reg, m_data_next;
    // configuration
    logic [CFG_WIDTH-1:0]   min_span_reg, min_span_next;
    logic [CFG_WIDTH-1:0]   max_gap_reg, max_gap_next;
    logic [COS_WIDTH-1:0]   cos_reg, cos_next;

    logic                   s_fire;
    logic                   seen_pend;
    logic                   out_free;
    logic                   out_load;
    logic                   go;
    m_word_t                out_word;
    point_t                 in_pt;
    verdict_t               verdict;

    assign s_fire    = s_valid && s_ready;
    // the unreachable fourth code counts as a pending point
    assign seen_pend = (seen_reg != SEEN_NONE) && (seen_reg != SEEN_FIRST);
    assign out_free  = !m_valid_reg || m_ready;
    assign in_pt     = '{x: s_data.px, y: s_data.py, z: s_data.pz};
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    psvf_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .go            (go),
        .pt_prev       (prev_reg),
        .pt_pend       (pend_reg),
        .pt_cur        (cur_reg),
        .pt_kept       (kept_reg),
        .min_span_sq   (min_span_reg),
        .max_gap_sq    (max_gap_reg),
        .cos_threshold (cos_reg),
        .verdict       (verdict)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (seen_pend) begin
                        state_next = ST_JUDGE;
                    end else if (seen_reg == SEEN_NONE || s_data.end_of_path) begin
                        state_next = ST_EMIT_CUR;
                    end
                end
            end
            ST_JUDGE: begin
                if (verdict.valid) begin
                    if (verdict.keep) begin
                        state_next = ST_EMIT_PEND;
                    end else begin
                        state_next = last_reg ? ST_EMIT_CUR : ST_IDLE;
                    end
                end
            end
            ST_EMIT_PEND: if (out_free) state_next = last_reg ? ST_EMIT_CUR : ST_IDLE;
            ST_EMIT_CUR:  if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        go       = (state_reg == ST_IDLE) && s_fire && seen_pend;
        out_load = out_free && (state_reg == ST_EMIT_PEND || state_reg == ST_EMIT_CUR);
        // the judged point sits in prev once the verdict is taken
        if (state_reg == ST_EMIT_PEND) begin
            out_word = '{qx: prev_reg.x, qy: prev_reg.y, qz: prev_reg.z, final_point: 1'b0};
        end else begin
            out_word = '{qx: cur_reg.x, qy: cur_reg.y, qz: cur_reg.z, final_point: last_reg};
        end
    end

    // point history, output register and configuration
    always_comb begin
        seen_next     = seen_reg;
        prev_next     = prev_reg;
        pend_next     = pend_reg;
        kept_next     = kept_reg;
        cur_next      = cur_reg;
        last_next     = last_reg;
        min_span_next = min_span_reg;
        max_gap_next  = max_gap_reg;
        cos_next      = cos_reg;
        m_valid_next  = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next   = out_load ? out_word : m_data_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MIN_SPAN: min_span_next = cfg_wdata;
                CFG_MAX_GAP:  max_gap_next  = cfg_wdata;
                CFG_COS:      cos_next      = cfg_wdata[COS_WIDTH-1:0];
                default:      cos_next      = cos_reg;
            endcase
        end

        if (s_fire) begin
            cur_next  = in_pt;
            last_next = s_data.end_of_path;
            if (seen_reg == SEEN_NONE) begin
                // first point of a polyline is always kept
                kept_next = in_pt;
                prev_next = in_pt;
                seen_next = s_data.end_of_path ? SEEN_NONE : SEEN_FIRST;
            end else if (seen_reg == SEEN_FIRST) begin
                if (s_data.end_of_path) begin
                    kept_next = in_pt;
                    seen_next = SEEN_NONE;
                end else begin
                    pend_next = in_pt;
                    seen_next = SEEN_PEND;
                end
            end
        end

        if (state_reg == ST_JUDGE && verdict.valid) begin
            prev_next = pend_reg;
            if (last_reg) begin
                kept_next = cur_reg;
                seen_next = SEEN_NONE;
            end else begin
                kept_next = verdict.keep ? pend_reg : kept_reg;
                pend_next = cur_reg;
                seen_next = SEEN_PEND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seen_reg     <= SEEN_NONE;
            m_valid_reg  <= 1'b0;
            min_span_reg <= MIN_SPAN_RESET;
            max_gap_reg  <= MAX_GAP_RESET;
            cos_reg      <= COS_RESET;
        end else begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            m_valid_reg  <= m_valid_next;
            min_span_reg <= min_span_next;
            max_gap_reg  <= max_gap_next;
            cos_reg      <= cos_next;
        end
        prev_reg   <= prev_next;
        pend_reg   <= pend_next;
        kept_reg   <= kept_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    // a verdict only arrives while a point is being judged
    a_verdict_judge: assert property (@(posedge aclk) disable iff (!aresetn)
        verdict.valid |-> state_reg == ST_JUDGE)
        else $error("verdict outside judgment");

    // a first point always produces a word
    a_first_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && seen_reg == SEEN_NONE) |=> state_reg == ST_EMIT_CUR)
        else $error("first point not emitted");

    // after the final word the polyline state is cleared
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_word.final_point) |=> seen_reg == SEEN_NONE)
        else $error("polyline state left after final word");

    // a word is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending word overwritten");

endmodule
`default_nettype wire
